### rtl/sc1t_pkg.sv
`default_nettype none

package sc1t_pkg;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [7:0] SC_UP       = 8'h48;
    localparam logic [7:0] SC_DOWN     = 8'h50;
    localparam logic [7:0] SC_LEFT     = 8'h4B;
    localparam logic [7:0] SC_RIGHT    = 8'h4D;
    localparam int unsigned ROM_SIZE   = 58;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_UP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_DOWN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEFT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RIGHT = 2'd3;

    localparam logic [7:0] RST_CODE_UP    = 8'd128;
    localparam logic [7:0] RST_CODE_DOWN  = 8'd129;
    localparam logic [7:0] RST_CODE_LEFT  = 8'd130;
    localparam logic [7:0] RST_CODE_RIGHT = 8'd131;

    typedef struct packed {
        logic [7:0] up;
        logic [7:0] down;
        logic [7:0] left;
        logic [7:0] right;
    } arrow_codes_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } fifo_req_t;

    typedef struct packed {
        logic popped;
        logic dropped;
    } fifo_stat_t;

    // US QWERTY layout for set-1 make codes below ROM_SIZE.
    function automatic logic [7:0] qwerty_lookup(input logic [5:0] sc);
        logic [7:0] ch;
        case (sc)
            6'd1:  ch = 8'h1B;
            6'd2:  ch = 8'h31;
            6'd3:  ch = 8'h32;
            6'd4:  ch = 8'h33;
            6'd5:  ch = 8'h34;
            6'd6:  ch = 8'h35;
            6'd7:  ch = 8'h36;
            6'd8:  ch = 8'h37;
            6'd9:  ch = 8'h38;
            6'd10: ch = 8'h39;
            6'd11: ch = 8'h30;
            6'd12: ch = 8'h2D;
            6'd13: ch = 8'h3D;
            6'd14: ch = 8'h08;
            6'd15: ch = 8'h09;
            6'd16: ch = 8'h71;
            6'd17: ch = 8'h77;
            6'd18: ch = 8'h65;
            6'd19: ch = 8'h72;
            6'd20: ch = 8'h74;
            6'd21: ch = 8'h79;
            6'd22: ch = 8'h75;
            6'd23: ch = 8'h69;
            6'd24: ch = 8'h6F;
            6'd25: ch = 8'h70;
            6'd26: ch = 8'h5B;
            6'd27: ch = 8'h5D;
            6'd28: ch = 8'h0A;
            6'd30: ch = 8'h61;
            6'd31: ch = 8'h73;
            6'd32: ch = 8'h64;
            6'd33: ch = 8'h66;
            6'd34: ch = 8'h67;
            6'd35: ch = 8'h68;
            6'd36: ch = 8'h6A;
            6'd37: ch = 8'h6B;
            6'd38: ch = 8'h6C;
            6'd39: ch = 8'h3B;
            6'd40: ch = 8'h27;
            6'd41: ch = 8'h60;
            6'd43: ch = 8'h5C;
            6'd44: ch = 8'h7A;
            6'd45: ch = 8'h78;
            6'd46: ch = 8'h63;
            6'd47: ch = 8'h76;
            6'd48: ch = 8'h62;
            6'd49: ch = 8'h6E;
            6'd50: ch = 8'h6D;
            6'd51: ch = 8'h2C;
            6'd52: ch = 8'h2E;
            6'd53: ch = 8'h2F;
            6'd55: ch = 8'h2A;
            6'd57: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### rtl/sc1t_xlate.sv
`default_nettype none

module sc1t_xlate (
    input  wire logic [7:0]            scan_byte,
    input  wire logic                  ext_flag,
    input  wire sc1t_pkg::arrow_codes_t codes,
    output logic [7:0]                 event_code,
    output logic                       ext_flag_next
);

    logic [7:0] arrow_code;
    logic       is_arrow;
    logic [7:0] rom_code;

    always_comb begin
        is_arrow   = 1'b1;
        arrow_code = 8'h00;
        case (scan_byte)
            sc1t_pkg::SC_UP:    arrow_code = codes.up;
            sc1t_pkg::SC_DOWN:  arrow_code = codes.down;
            sc1t_pkg::SC_LEFT:  arrow_code = codes.left;
            sc1t_pkg::SC_RIGHT: arrow_code = codes.right;
            default:            is_arrow   = 1'b0;
        endcase
    end

    assign rom_code = (scan_byte < 8'(sc1t_pkg::ROM_SIZE))
                    ? sc1t_pkg::qwerty_lookup(scan_byte[5:0]) : 8'h00;

    always_comb begin
        event_code    = 8'h00;
        ext_flag_next = ext_flag;
        if (scan_byte == sc1t_pkg::PREFIX_BYTE) begin
            ext_flag_next = 1'b1;
        end else if (scan_byte[7]) begin
            ext_flag_next = 1'b0;
        end else if (ext_flag) begin
            ext_flag_next = 1'b0;
            event_code    = arrow_code;
        end else if (is_arrow) begin
            event_code = arrow_code;
        end else begin
            event_code = rom_code;
        end
    end

endmodule

`default_nettype wire

### rtl/sc1t_fifo.sv
`default_nettype none

module sc1t_fifo #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire sc1t_pkg::fifo_req_t    req,
    output sc1t_pkg::fifo_stat_t        stat,
    output logic [CNT_W-1:0]            count_next,
    output logic [7:0]                  rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       rd_data_reg;
    logic             do_push;
    logic             do_pop;

    assign do_push = req.push && (req.wdata != 8'h00) && (count_reg != CNT_FULL);
    assign do_pop  = req.pop && (count_reg != '0);

    assign stat.popped  = do_pop;
    assign stat.dropped = req.push && (req.wdata != 8'h00) && (count_reg == CNT_FULL);

    assign wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        if (do_push) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= req.wdata;
        end
        if (do_pop) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/scan_code_set1_translator_fifo.sv
// A word accepted on the slave side sits in the input register and is moved into the result
// register once that register is empty or m_tready is high; it is then offered on the master
// side from the result register, and waits there while m_tready is held low.
// Throughput: one word per cycle unless m_tready stalls; queue pointers and count are registers.
// Reset: aresetn is synchronous and active low; it empties the queue, clears the prefix
// flag and both pipeline stages, and returns the arrow code registers to 128 to 131.
`default_nettype none

module scan_code_set1_translator_fifo #(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  wire logic        s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] event_code, [13:8] pending_count,
                                        // [14] dropped, [15] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [sc1t_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    sc1t_pkg::arrow_codes_t codes_reg;
    logic                   ext_reg;

    logic       in_valid_reg;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;

    logic       out_valid_reg;
    logic       out_hit_reg;
    logic [5:0] out_count_reg;
    logic       out_drop_reg;

    logic       advance;
    logic [7:0] xl_event;
    logic       xl_ext_next;

    sc1t_pkg::fifo_req_t  fifo_req;
    sc1t_pkg::fifo_stat_t fifo_stat;
    logic [CNT_W-1:0]     fifo_count_next;
    logic [7:0]           fifo_rd_data;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    sc1t_xlate u_xlate (
        .scan_byte     (in_byte_reg),
        .ext_flag      (ext_reg),
        .codes         (codes_reg),
        .event_code    (xl_event),
        .ext_flag_next (xl_ext_next)
    );

    assign fifo_req.push  = advance && !in_mode_reg;
    assign fifo_req.pop   = advance && in_mode_reg;
    assign fifo_req.wdata = xl_event;

    sc1t_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (fifo_req),
        .stat       (fifo_stat),
        .count_next (fifo_count_next),
        .rd_data    (fifo_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.up    <= sc1t_pkg::RST_CODE_UP;
            codes_reg.down  <= sc1t_pkg::RST_CODE_DOWN;
            codes_reg.left  <= sc1t_pkg::RST_CODE_LEFT;
            codes_reg.right <= sc1t_pkg::RST_CODE_RIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                sc1t_pkg::CFG_CODE_UP:    codes_reg.up    <= cfg_data;
                sc1t_pkg::CFG_CODE_DOWN:  codes_reg.down  <= cfg_data;
                sc1t_pkg::CFG_CODE_LEFT:  codes_reg.left  <= cfg_data;
                sc1t_pkg::CFG_CODE_RIGHT: codes_reg.right <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ext_reg       <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                if (!in_mode_reg) begin
                    ext_reg <= xl_ext_next;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_hit_reg   <= fifo_stat.popped;
            out_count_reg <= 6'(fifo_count_next);
            out_drop_reg  <= fifo_stat.dropped;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_drop_reg, out_count_reg,
                       out_hit_reg ? fifo_rd_data : 8'h00};

endmodule

`default_nettype wire

### rtl/sc1t_checker.sv
`default_nettype none

module sc1t_checker #(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // A stalled result word must not change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // A dropped event belongs to a scan code, never to a read.
    a_drop_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> (m_tdata[7:0] == 8'h00))
        else $error("dropped flag set on a word carrying an event");

    // Dropping only happens with a full queue, so the count shows the depth.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> (m_tdata[13:8] == 6'(QUEUE_DEPTH)))
        else $error("dropped flag with inconsistent count");

    // No result word is presented straight after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[15])
        else $error("padding bit set");

endmodule

bind scan_code_set1_translator_fifo sc1t_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sc1t_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### test/scan_code_set1_translator_fifo_test.sv
`timescale 1ns / 100ps

module scan_code_set1_translator_fifo_test;

    localparam int unsigned QUEUE_DEPTH = 32;

    typedef struct packed {
        logic       dropped;
        logic [5:0] pending;
        logic [7:0] code;
    } key_word_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [sc1t_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                     cfg_data;

    sc1t_pkg::arrow_codes_t arrows;
    logic         ext_armed;
    logic [7:0]   queued_keys[$];
    key_word_t    expected_words[$];
    int           errors;
    int           items_sent;
    bit           no_gaps;
    bit           ready_always;
    int           hold_request;

    scan_code_set1_translator_fifo #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] qwerty_char(input logic [5:0] sc);
        case (sc)
            6'd1: return 8'h1B;  6'd2: return 8'h31;  6'd3: return 8'h32;  6'd4: return 8'h33;
            6'd5: return 8'h34;  6'd6: return 8'h35;  6'd7: return 8'h36;  6'd8: return 8'h37;
            6'd9: return 8'h38;  6'd10: return 8'h39; 6'd11: return 8'h30; 6'd12: return 8'h2D;
            6'd13: return 8'h3D; 6'd14: return 8'h08; 6'd15: return 8'h09; 6'd16: return 8'h71;
            6'd17: return 8'h77; 6'd18: return 8'h65; 6'd19: return 8'h72; 6'd20: return 8'h74;
            6'd21: return 8'h79; 6'd22: return 8'h75; 6'd23: return 8'h69; 6'd24: return 8'h6F;
            6'd25: return 8'h70; 6'd26: return 8'h5B; 6'd27: return 8'h5D; 6'd28: return 8'h0A;
            6'd30: return 8'h61; 6'd31: return 8'h73; 6'd32: return 8'h64; 6'd33: return 8'h66;
            6'd34: return 8'h67; 6'd35: return 8'h68; 6'd36: return 8'h6A; 6'd37: return 8'h6B;
            6'd38: return 8'h6C; 6'd39: return 8'h3B; 6'd40: return 8'h27; 6'd41: return 8'h60;
            6'd43: return 8'h5C; 6'd44: return 8'h7A; 6'd45: return 8'h78; 6'd46: return 8'h63;
            6'd47: return 8'h76; 6'd48: return 8'h62; 6'd49: return 8'h6E; 6'd50: return 8'h6D;
            6'd51: return 8'h2C; 6'd52: return 8'h2E; 6'd53: return 8'h2F; 6'd55: return 8'h2A;
            6'd57: return 8'h20;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] arrow_key_code(input logic [7:0] sc);
        case (sc)
            sc1t_pkg::SC_UP:    return arrows.up;
            sc1t_pkg::SC_DOWN:  return arrows.down;
            sc1t_pkg::SC_LEFT:  return arrows.left;
            sc1t_pkg::SC_RIGHT: return arrows.right;
            default:            return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] pick_arrow();
        case ($urandom_range(0, 3))
            0:       return sc1t_pkg::SC_UP;
            1:       return sc1t_pkg::SC_DOWN;
            2:       return sc1t_pkg::SC_LEFT;
            default: return sc1t_pkg::SC_RIGHT;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic predict_word(input logic mode, input logic [7:0] sc);
        key_word_t  w;
        logic [7:0] ch;
        w = '0;
        ch = 8'h00;
        if (mode) begin
            if (queued_keys.size() > 0) w.code = queued_keys.pop_front();
        end else begin
            if (sc == sc1t_pkg::PREFIX_BYTE) begin
                ext_armed = 1'b1;
            end else if (sc[7]) begin
                ext_armed = 1'b0;
            end else if (ext_armed) begin
                ext_armed = 1'b0;
                ch = arrow_key_code(sc);
            end else if (sc < sc1t_pkg::ROM_SIZE) begin
                ch = qwerty_char(sc[5:0]);
            end else begin
                ch = arrow_key_code(sc);
            end
            if (ch != 8'h00) begin
                if (queued_keys.size() >= QUEUE_DEPTH) w.dropped = 1'b1;
                else queued_keys.push_back(ch);
            end
        end
        w.pending = 6'(queued_keys.size());
        expected_words.push_back(w);
    endtask

    task automatic send_word(input logic mode, input logic [7:0] sc);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= sc;
        do @(posedge aclk); while (!s_tready);
        predict_word(mode, sc);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sc1t_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sc1t_pkg::CFG_CODE_UP:    arrows.up    = value;
            sc1t_pkg::CFG_CODE_DOWN:  arrows.down  = value;
            sc1t_pkg::CFG_CODE_LEFT:  arrows.left  = value;
            sc1t_pkg::CFG_CODE_RIGHT: arrows.right = value;
            default: ;
        endcase
    endtask

    task automatic set_arrows(input logic [7:0] up, input logic [7:0] down,
                              input logic [7:0] left, input logic [7:0] right);
        write_reg(sc1t_pkg::CFG_CODE_UP, up);
        write_reg(sc1t_pkg::CFG_CODE_DOWN, down);
        write_reg(sc1t_pkg::CFG_CODE_LEFT, left);
        write_reg(sc1t_pkg::CFG_CODE_RIGHT, right);
    endtask

    task automatic send_random_item(input int read_pct);
        logic [7:0] sc;
        if ($urandom_range(0, 99) < read_pct) begin
            send_word(1'b1, 8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_word(1'b0, 8'($urandom_range(0, 57)));
            4: send_word(1'b0, pick_arrow());
            5: begin
                sc = pick_arrow();
                send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
                send_word(1'b0, sc);
                send_word(1'b0, sc | 8'h80);
            end
            6: send_word(1'b0, 8'($urandom_range(0, 127)) | 8'h80);
            7: begin
                sc = 8'($urandom_range(0, 57));
                send_word(1'b0, sc);
                send_word(1'b0, sc | 8'h80);
            end
            8: begin
                send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
                send_word(1'b0, 8'($urandom_range(0, 255)));
            end
            default: send_word(1'b0, 8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic test_directed();
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'h1E);
        send_word(1'b0, 8'h9E);
        send_word(1'b0, sc1t_pkg::SC_UP);
        send_word(1'b0, sc1t_pkg::SC_DOWN);
        send_word(1'b0, sc1t_pkg::SC_LEFT);
        send_word(1'b0, sc1t_pkg::SC_RIGHT);
        send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
        send_word(1'b0, sc1t_pkg::SC_UP);
        send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
        send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
        send_word(1'b0, sc1t_pkg::SC_DOWN);
        send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
        send_word(1'b0, 8'h1E);
        send_word(1'b0, 8'h1E);
        send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
        send_word(1'b0, 8'hC8);
        send_word(1'b0, sc1t_pkg::SC_LEFT);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h1D);
        send_word(1'b0, 8'h39);
        send_word(1'b0, 8'h3A);
        send_word(1'b0, 8'h7F);
        send_word(1'b1, 8'h00);
    endtask

    task automatic test_arrow_registers();
        set_arrows(8'd1, 8'd1, 8'd1, 8'd1);
        send_word(1'b0, sc1t_pkg::SC_UP);
        send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
        send_word(1'b0, sc1t_pkg::SC_RIGHT);
        set_arrows(8'd255, 8'd255, 8'd255, 8'd255);
        send_word(1'b0, sc1t_pkg::SC_DOWN);
        send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
        send_word(1'b0, sc1t_pkg::SC_LEFT);
        write_reg(sc1t_pkg::CFG_CODE_LEFT, 8'd0);
        send_word(1'b0, sc1t_pkg::SC_LEFT);
        send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
        send_word(1'b0, sc1t_pkg::SC_LEFT);
        set_arrows(8'd17, 8'd34, 8'd51, 8'd68);
        send_word(1'b0, sc1t_pkg::SC_UP);
        send_word(1'b0, sc1t_pkg::SC_DOWN);
        send_word(1'b0, sc1t_pkg::SC_LEFT);
        send_word(1'b0, sc1t_pkg::SC_RIGHT);
    endtask

    task automatic test_full_queue();
        int n;
        n = queued_keys.size();
        repeat (n) send_word(1'b1, 8'($urandom_range(0, 255)));
        send_word(1'b1, 8'h00);
        for (int i = 0; i < QUEUE_DEPTH + 3; i++) send_word(1'b0, 8'(8'h10 + i % 12));
        send_word(1'b0, sc1t_pkg::PREFIX_BYTE);
        send_word(1'b0, sc1t_pkg::SC_UP);
        repeat (QUEUE_DEPTH + 1) send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_receiver_hold();
        no_gaps = 1'b1;
        hold_request = 300;
        for (int i = 0; i < 60; i++) begin
            send_word(i % 3 == 2, 8'($urandom_range(2, 13)));
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_random_traffic();
        int read_pct[6] = '{45, 20, 65, 50, 35, 75};
        int target;
        for (int p = 0; p < 6; p++) begin
            case (p)
                1: set_arrows(8'd1, 8'd255, 8'd1, 8'd255);
                2, 4: set_arrows(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
                3: set_arrows(8'd255, 8'd254, 8'd2, 8'd1);
                5: set_arrows(sc1t_pkg::RST_CODE_UP, sc1t_pkg::RST_CODE_DOWN,
                              sc1t_pkg::RST_CODE_LEFT, sc1t_pkg::RST_CODE_RIGHT);
                default: ;
            endcase
            no_gaps = (p == 3);
            ready_always = (p == 3);
            target = items_sent + 285;
            while (items_sent < target) begin
                send_random_item(read_pct[p]);
                if (p == 2 && items_sent == target - 140) drain_results();
            end
        end
        no_gaps = 1'b0;
        ready_always = 1'b0;
    endtask

    initial begin : ready_driver
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (hold_request > 0) begin
                m_tready <= 1'b0;
                stall_left = hold_request - 1;
                hold_request = 0;
            end else if (!ready_always && $urandom_range(0, 99) < 15) begin
                m_tready <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(7, 39);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        key_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                if (errors < 10) $display("unexpected word %04h", m_tdata);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (m_tdata[7:0] != want.code || m_tdata[13:8] != want.pending ||
                    m_tdata[14] != want.dropped || m_tdata[15] != 1'b0) begin
                    if (errors < 10) begin
                        $display({"mismatch: expected code %02h pending %0d dropped %0b, ",
                                  "got code %02h pending %0d dropped %0b top %0b"},
                                 want.code, want.pending, want.dropped, m_tdata[7:0],
                                 m_tdata[13:8], m_tdata[14], m_tdata[15]);
                    end
                    errors++;
                end
            end
        end
    end

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= sc1t_pkg::CFG_CODE_UP;
        cfg_data  <= 8'h00;
        aresetn   <= 1'b0;
        hold_request = 0;
        no_gaps = 1'b0;
        ready_always = 1'b0;
        errors = 0;
        items_sent = 0;
        arrows = '{sc1t_pkg::RST_CODE_UP, sc1t_pkg::RST_CODE_DOWN,
                   sc1t_pkg::RST_CODE_LEFT, sc1t_pkg::RST_CODE_RIGHT};
        ext_armed = 1'b0;
        queued_keys.delete();
        expected_words.delete();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_arrow_registers();
        test_full_queue();
        test_receiver_hold();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge aclk);
        if (expected_words.size() != 0) errors++;
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### scan_code_set1_translator_fifo.f
rtl/sc1t_pkg.sv
rtl/sc1t_xlate.sv
rtl/sc1t_fifo.sv
rtl/scan_code_set1_translator_fifo.sv
rtl/sc1t_checker.sv
test/scan_code_set1_translator_fifo_test.sv
